// ----- hw/rtl/sobel_edge_magnitude_core_macros.svh -----
// Assertion macros shared by the Sobel edge magnitude core.
// Each macro takes a label, clock, reset, antecedent, consequent and message.
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SEM_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/sem_pkg.sv -----
`timescale 1ns / 1ps
package sem_pkg;

   // Field and datapath widths
   localparam int PIX_W     = 8;
   localparam int CFG_W     = 12;
   localparam int TAG_W     = 11;
   localparam int MAG_W     = 10;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int SUM_W     = SQ_W + 1;
   localparam int ROOT_W    = 11;
   localparam int ROOT_TOP  = 2 * (ROOT_W - 1);

   // Frame geometry
   localparam int MAX_WIDTH_DEF    = 2048;
   localparam int MAX_HEIGHT_DEF   = 2048;
   localparam int LINE_WIDTH_RST   = 640;
   localparam int FRAME_HEIGHT_RST = 480;
   localparam int MIN_SIZE         = 3;
   localparam int EDGE_MAX         = 255;

   // Register map
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LINE_WIDTH   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SQUARE,
      S_LAUNCH,
      S_ROOT,
      S_OUT
   } state_type;

   // Status of the root unit
   typedef struct packed {
      logic busy;
      logic done;
   } root_status_type;

   // Clamp a size register to [MIN_SIZE, hi]
   function automatic int clamp_size(input int v, input int hi);
      int r;
      r = v;
      if (v < MIN_SIZE) begin
         r = MIN_SIZE;
      end else if (v > hi) begin
         r = hi;
      end
      return r;
   endfunction

   // Weighted column or row sum p0 + 2*p1 + p2
   function automatic logic [MAG_W-1:0] wsum(input logic [PIX_W-1:0] p0,
                                             input logic [PIX_W-1:0] p1,
                                             input logic [PIX_W-1:0] p2);
      return MAG_W'(p0) + (MAG_W'(p1) << 1) + MAG_W'(p2);
   endfunction

endpackage

// ----- hw/rtl/sobel_edge_magnitude_core.sv -----
// Sobel 3x3 gradient magnitude over a raster pixel stream.
// Border pixel: the beat is taken and written back to the line store; no result beat.
// Interior pixel: the beat passes the line store read, squaring, the 11-step bit-serial square root unit
//   and the output register (states READ, SQUARE, LAUNCH, ROOT, OUT); the next input waits for the result load.
// Synchronous active-high reset clears the counters, the sequencer and the output valid;
//   the size registers return to 640 by 480, line stores are not cleared.
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_core_macros.svh"
module sobel_edge_magnitude_core import sem_pkg::*; #(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PIX_W-1:0]     req_pixel_in,
   input  logic                 req_start_of_frame,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [PIX_W-1:0]     rsp_edge_value,
   output logic [TAG_W-1:0]     rsp_out_row,
   output logic [TAG_W-1:0]     rsp_out_col,
   output logic                 rsp_last_of_frame
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam logic [WW-1:0] W_RST = WW'(clamp_size(LINE_WIDTH_RST, MAX_WIDTH));
   localparam logic [HW-1:0] H_RST = HW'(clamp_size(FRAME_HEIGHT_RST, MAX_HEIGHT));

   typedef struct packed {
      logic take;
      logic mem_wr;
      logic shift;
      logic square;
      logic root_start;
      logic out_load;
   } ctl_type;

   state_type       state_ff, state_in;
   ctl_type         ctl;
   root_status_type root_st;

   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_ff, h_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   logic          accept;
   logic [CW-1:0] col_start, cur_col;
   logic [RW-1:0] row_start, cur_row;
   logic [RW:0]   row_step;
   logic          wrap_start;

   logic [CW-1:0]    c_ff;
   logic [RW-1:0]    r_ff;
   logic [PIX_W-1:0] px_ff;
   logic             interior_ff;
   logic             last_ff;
   logic [TAG_W-1:0] tag_row_ff, tag_col_ff;

   logic [2*PIX_W-1:0] mem_rd_data;
   logic [MAG_W-1:0]   abs_gx, abs_gy;
   logic [SQ_W-1:0]    sq_x_ff, sq_y_ff;
   logic [ROOT_W-1:0]  root;

   logic             rsp_valid_ff;
   logic [PIX_W-1:0] rsp_edge_ff;
   logic [TAG_W-1:0] rsp_row_ff, rsp_col_ff;
   logic             rsp_last_ff;

   // Size registers, clamped on write
   always_comb begin
      w_in = w_ff;
      h_in = h_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_LINE_WIDTH:   w_in = WW'(clamp_size(int'(csr_wdata), MAX_WIDTH));
            REG_FRAME_HEIGHT: h_in = HW'(clamp_size(int'(csr_wdata), MAX_HEIGHT));
            default:          w_in = w_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= W_RST;
         h_ff <= H_RST;
      end else begin
         w_ff <= w_in;
         h_ff <= h_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_READ;
         S_READ:   state_in = interior_ff ? S_SQUARE : S_IDLE;
         S_SQUARE: state_in = S_LAUNCH;
         S_LAUNCH: state_in = S_ROOT;
         S_ROOT:   if (root_st.done) state_in = S_OUT;
         S_OUT:    if (!rsp_valid_ff || !rsp_stall) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      ctl            = '0;
      ctl.take       = (state_ff == S_IDLE);
      ctl.mem_wr     = (state_ff == S_READ);
      ctl.shift      = (state_ff == S_READ);
      ctl.square     = (state_ff == S_SQUARE);
      ctl.root_start = (state_ff == S_LAUNCH);
      ctl.out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = !ctl.take;
   assign accept    = req_valid && ctl.take;

   // Position of the arriving pixel
   always_comb begin
      col_start  = req_start_of_frame ? '0 : col_ff;
      row_start  = req_start_of_frame ? '0 : row_ff;
      wrap_start = WW'(col_start) >= w_ff;
      cur_col    = wrap_start ? '0 : col_start;
      row_step   = wrap_start ? ((RW + 1)'(row_start) + 1'b1) : (RW + 1)'(row_start);
      cur_row    = (32'(row_step) >= 32'(h_ff)) ? '0 : RW'(row_step);
   end

   // Advance the counts once the pixel is stored
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (ctl.mem_wr) begin
         if (32'(c_ff) + 32'd1 >= 32'(w_ff)) begin
            col_in = '0;
            row_in = (32'(r_ff) + 32'd1 >= 32'(h_ff)) ? '0 : RW'(32'(r_ff) + 32'd1);
         end else begin
            col_in = CW'(32'(c_ff) + 32'd1);
            row_in = r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Hold the beat and its tags
   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff        <= cur_col;
         r_ff        <= cur_row;
         px_ff       <= req_pixel_in;
         interior_ff <= (32'(cur_row) >= 32'd2) && (32'(cur_col) >= 32'd2);
         last_ff     <= (32'(cur_row) + 32'd1 == 32'(h_ff))
                     && (32'(cur_col) + 32'd1 == 32'(w_ff));
         tag_row_ff  <= TAG_W'(32'(cur_row) - 32'd1);
         tag_col_ff  <= TAG_W'(32'(cur_col) - 32'd1);
      end
   end

   // Two rows above, packed as {two above, one above}
   sem_line_store #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (2 * PIX_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (mem_rd_data),
      .wr_en   (ctl.mem_wr),
      .wr_addr (c_ff),
      .wr_data ({mem_rd_data[PIX_W-1:0], px_ff})
   );

   sem_window u_window (
      .clock    (clock),
      .shift_en (ctl.shift),
      .top_px   (mem_rd_data[2*PIX_W-1:PIX_W]),
      .mid_px   (mem_rd_data[PIX_W-1:0]),
      .bot_px   (px_ff),
      .abs_gx   (abs_gx),
      .abs_gy   (abs_gy)
   );

   // Square both gradients
   always_ff @(posedge clock) begin
      if (ctl.square) begin
         sq_x_ff <= SQ_W'(abs_gx) * SQ_W'(abs_gx);
         sq_y_ff <= SQ_W'(abs_gy) * SQ_W'(abs_gy);
      end
   end

   sem_root u_root (
      .clock   (clock),
      .reset   (reset),
      .start   (ctl.root_start),
      .operand (SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff)),
      .status  (root_st),
      .root    (root)
   );

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_edge_ff <= (root[ROOT_W-1:PIX_W] != '0) ? PIX_W'(EDGE_MAX) : root[PIX_W-1:0];
         rsp_row_ff  <= tag_row_ff;
         rsp_col_ff  <= tag_col_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_edge_value    = rsp_edge_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_last_of_frame = rsp_last_ff;

   `SEM_ASSERT_NEXT(a_read_follows_accept, clock, reset, accept, state_ff == S_READ, "line store read not followed by write back")
   `SEM_ASSERT_IMP(a_done_in_root, clock, reset, root_st.done, state_ff == S_ROOT, "root result outside root wait")
   `SEM_ASSERT_IMP(a_root_not_stuck, clock, reset, state_ff == S_ROOT && !root_st.busy, root_st.done, "root wait with idle root unit")

endmodule

// ----- hw/rtl/sem_line_store.sv -----
`timescale 1ns / 1ps
module sem_line_store import sem_pkg::*; #(
   parameter int DEPTH  = MAX_WIDTH_DEF,
   parameter int DATA_W = 2 * PIX_W
) (
   input  logic                     clock,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data
);

   logic [DATA_W-1:0] line_mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/sem_window.sv -----
`timescale 1ns / 1ps
module sem_window import sem_pkg::*; (
   input  logic             clock,
   input  logic             shift_en,
   input  logic [PIX_W-1:0] top_px,
   input  logic [PIX_W-1:0] mid_px,
   input  logic [PIX_W-1:0] bot_px,
   output logic [MAG_W-1:0] abs_gx,
   output logic [MAG_W-1:0] abs_gy
);

   // Column c-2 (a) and c-1 (b): index 0 top, 1 middle, 2 bottom
   logic [PIX_W-1:0] col_a_ff [3];
   logic [PIX_W-1:0] col_b_ff [3];
   logic signed [MAG_W:0] gx;
   logic signed [MAG_W:0] gy;
   logic [MAG_W-1:0] abs_gx_in, abs_gy_in;
   logic [MAG_W-1:0] abs_gx_ff, abs_gy_ff;

   // Form both gradients against the arriving column
   always_comb begin
      gx = $signed({1'b0, wsum(top_px, mid_px, bot_px)})
         - $signed({1'b0, wsum(col_a_ff[0], col_a_ff[1], col_a_ff[2])});
      gy = $signed({1'b0, wsum(col_a_ff[2], col_b_ff[2], bot_px)})
         - $signed({1'b0, wsum(col_a_ff[0], col_b_ff[0], top_px)});
      abs_gx_in = gx[MAG_W] ? MAG_W'(-gx) : MAG_W'(gx);
      abs_gy_in = gy[MAG_W] ? MAG_W'(-gy) : MAG_W'(gy);
   end

   // Advance the window and hold the magnitudes
   always_ff @(posedge clock) begin
      if (shift_en) begin
         col_a_ff[0] <= col_b_ff[0];
         col_a_ff[1] <= col_b_ff[1];
         col_a_ff[2] <= col_b_ff[2];
         col_b_ff[0] <= top_px;
         col_b_ff[1] <= mid_px;
         col_b_ff[2] <= bot_px;
         abs_gx_ff   <= abs_gx_in;
         abs_gy_ff   <= abs_gy_in;
      end
   end

   assign abs_gx = abs_gx_ff;
   assign abs_gy = abs_gy_ff;

endmodule

// ----- hw/rtl/sem_root.sv -----
`timescale 1ns / 1ps
`include "sobel_edge_magnitude_core_macros.svh"
module sem_root import sem_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  operand,
   output root_status_type   status,
   output logic [ROOT_W-1:0] root
);

   localparam int RES_W = SUM_W + 1;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [RES_W-1:0] res_ff, res_in;
   logic [RES_W-1:0] trial;
   logic [SUM_W-1:0] bit_ff, bit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // One result bit per cycle, restoring form
   always_comb begin
      trial   = RES_W'(res_ff) + RES_W'(bit_ff);
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = operand;
         res_in  = '0;
         bit_in  = SUM_W'(1) << ROOT_TOP;
         cnt_in  = CNT_W'(ROOT_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (RES_W'(rem_ff) >= trial) begin
            rem_in = SUM_W'(RES_W'(rem_ff) - trial);
            res_in = (res_ff >> 1) + RES_W'(bit_ff);
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      cnt_ff <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign root        = res_ff[ROOT_W-1:0];

   `SEM_ASSERT_IMP(a_root_start_idle, clock, reset, start, !busy_ff, "root started while busy")
   `SEM_ASSERT_NEXT(a_root_done, clock, reset, busy_ff && cnt_ff == '0 && !start, done_ff && !busy_ff, "root unit missed its last step")

endmodule
